### rtl/core/rbms_pkg.sv
package rbms_pkg;

    // Fixed-point format of every state word
    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    // dt is unsigned Q0.16
    localparam int DT_W      = 16;

    // Divider: |n| << FRAC_BITS, one quotient bit per cycle
    localparam int NUM_W   = WORD_W + FRAC_BITS;
    // Multiplier: 48-bit signed multiplicand by dt, one dt bit per cycle
    localparam int MCAND_W = WORD_W + DT_W;
    localparam int PROD_W  = MCAND_W + DT_W;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    // v*dt and a*dt carry DT_W fraction bits; a*dt*dt/2 drops 2*DT_W+1
    localparam int T1_LSB  = DT_W;
    localparam int T2_LSB  = 2 * DT_W + 1;
    localparam int T2_W    = PROD_W - T2_LSB;
    localparam int SUM_W   = WORD_W + 2;

    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [MCAND_W-1:0] mcand_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [DT_W-1:0]           dt_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t FIX_ONE  = word_t'(1 << FRAC_BITS);

    // Operation codes
    localparam logic [2:0] OP_FORCE    = 3'd0;
    localparam logic [2:0] OP_TORQUE   = 3'd1;
    localparam logic [2:0] OP_STEP     = 3'd2;
    localparam logic [2:0] OP_LOAD_POS = 3'd3;
    localparam logic [2:0] OP_LOAD_VEL = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_BODY_TYPE = 2'd0;
    localparam logic [1:0] REG_BODY_MASS = 2'd1;
    localparam logic [1:0] REG_INERTIA   = 2'd2;

    // Body types
    localparam logic [1:0] BODY_STATIC    = 2'd0;
    localparam logic [1:0] BODY_KINEMATIC = 2'd1;
    localparam logic [1:0] BODY_DYNAMIC   = 2'd2;

    // Request to the serial unit
    typedef struct packed {
        logic start;
        logic divide;
    } rbms_cmd_t;

    // Status back from the serial unit
    typedef struct packed {
        logic done;
        logic fault;
    } rbms_sts_t;

    function automatic word_t sat_word(input sum_t x);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &x[SUM_W-1:WORD_W-1];
        hi_zeros = ~(|x[SUM_W-1:WORD_W-1]);
        if (hi_ones || hi_zeros)
        begin
            return x[WORD_W-1:0];
        end
        return x[SUM_W-1] ? WORD_MIN : WORD_MAX;
    endfunction

endpackage

### rtl/core/rbms_item_if.sv
interface rbms_item_if import rbms_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    word_t      vec_x;
    word_t      vec_y;
    word_t      vec_z;
    word_t      torque_value;
    dt_t        time_step;

    modport source (
        output valid, operation, vec_x, vec_y, vec_z, torque_value, time_step,
        input  ready
    );
    modport sink (
        input  valid, operation, vec_x, vec_y, vec_z, torque_value, time_step,
        output ready
    );
endinterface

### rtl/core/rbms_result_if.sv
interface rbms_result_if import rbms_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t vel_x;
    word_t vel_y;
    word_t vel_z;
    word_t body_angle;
    word_t angular_rate;
    logic  divide_fault;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               body_angle, angular_rate, divide_fault,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               body_angle, angular_rate, divide_fault,
        output ready
    );
endinterface

### rtl/core/rbms_cfg_if.sv
interface rbms_cfg_if import rbms_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    word_t      data;

    modport source (
        output valid, reg_index, data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, data,
        output ready
    );
endinterface

### rtl/core/rbms_serial_alu.sv
// Shared bit-serial unit: restoring divide (one quotient bit a cycle)
// or shift-add multiply by dt (one dt bit a cycle).
module rbms_serial_alu import rbms_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  rbms_cmd_t cmd,
    input  word_t     num,
    input  word_t     den,
    input  mcand_t    mcand,
    input  dt_t       mplier,
    output rbms_sts_t sts,
    output word_t     quot,
    output prod_t     prod
);

    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(NUM_W);
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(DT_W);

    logic             busy_reg,   busy_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             div_reg,    div_next;
    logic             fault_reg,  fault_next;

    logic [NUM_W-1:0]  sh_reg,     sh_next;
    logic [WORD_W-1:0] dvs_reg,    dvs_next;
    logic [WORD_W-1:0] rem_reg,    rem_next;
    logic [WORD_W-1:0] q_reg,      q_next;
    logic              sticky_reg, sticky_next;
    logic              neg_reg,    neg_next;
    mcand_t            mcand_reg,  mcand_next;
    prod_t             prod_reg,   prod_next;

    logic [WORD_W-1:0] num_mag;
    logic [WORD_W-1:0] den_mag;
    logic [WORD_W:0]   part;
    logic [WORD_W:0]   diff;
    logic [MCAND_W:0]  psum;
    logic              ovf;

    assign num_mag = num[WORD_W-1] ? (~num + 1'b1) : num;
    assign den_mag = den[WORD_W-1] ? (~den + 1'b1) : den;
    assign part    = {rem_reg, sh_reg[NUM_W-1]};
    assign diff    = part - {1'b0, dvs_reg};
    assign psum    = {prod_reg[PROD_W-1], prod_reg[PROD_W-1:DT_W]}
                   + (prod_reg[0] ? {mcand_reg[MCAND_W-1], mcand_reg} : '0);

    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        div_next    = div_reg;
        fault_next  = fault_reg;
        sh_next     = sh_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        sticky_next = sticky_reg;
        neg_next    = neg_reg;
        mcand_next  = mcand_reg;
        prod_next   = prod_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            div_next  = cmd.divide;
            if (cmd.divide)
            begin
                q_next   = '0;
                rem_next = '0;
                sh_next  = {num_mag, {FRAC_BITS{1'b0}}};
                dvs_next = den_mag;
                if (den == '0)
                begin
                    // zero divisor: saturate by the numerator's sign; a zero numerator gives zero
                    cnt_next    = '0;
                    fault_next  = 1'b1;
                    sticky_next = |num;
                    neg_next    = num[WORD_W-1];
                end
                else
                begin
                    cnt_next    = DIV_STEPS;
                    fault_next  = 1'b0;
                    sticky_next = 1'b0;
                    neg_next    = num[WORD_W-1] ^ den[WORD_W-1];
                end
            end
            else
            begin
                cnt_next   = MUL_STEPS;
                fault_next = 1'b0;
                mcand_next = mcand;
                prod_next  = {{MCAND_W{1'b0}}, mplier};
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                if (div_reg)
                begin
                    sh_next     = {sh_reg[NUM_W-2:0], 1'b0};
                    sticky_next = sticky_reg | q_reg[WORD_W-1];
                    if (!diff[WORD_W])
                    begin
                        rem_next = diff[WORD_W-1:0];
                        q_next   = {q_reg[WORD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = part[WORD_W-1:0];
                        q_next   = {q_reg[WORD_W-2:0], 1'b0};
                    end
                end
                else
                begin
                    prod_next = {psum, prod_reg[DT_W-1:1]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            div_reg   <= 1'b0;
            fault_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            div_reg   <= div_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg     <= sh_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        sticky_reg <= sticky_next;
        neg_reg    <= neg_next;
        mcand_reg  <= mcand_next;
        prod_reg   <= prod_next;
    end

    // quotient over 31 bits of magnitude saturates
    assign ovf = sticky_reg | q_reg[WORD_W-1];

    always_comb
    begin
        if (neg_reg)
        begin
            quot = ovf ? WORD_MIN : word_t'(-q_reg);
        end
        else
        begin
            quot = ovf ? WORD_MAX : word_t'(q_reg);
        end
    end

    assign sts.done  = busy_reg && (cnt_reg == '0);
    assign sts.fault = fault_reg;
    assign prod      = prod_reg;

endmodule

### rtl/core/rigid_body_motion_step.sv
// Rigid body motion step: constant-acceleration integrator for one body.
// Channels: item (sink) takes one command word - force, torque, time step,
//   load position or load velocity; result (source) returns one word per
//   item with the position, velocity, angle and angular rate after it,
//   plus divide_fault; cfg (sink, always ready) writes body type, mass and rotational
//   inertia, and the user must use it only while the block is idle (not enforced).
// Work from item to result, done on one shared bit-serial unit:
//   force on a dynamic body  one divide by the mass per axis (48-bit restoring
//     divide, one quotient bit per cycle; a zero mass faults, skips the steps),
//   torque                   one divide by the inertia (a zero one skips the steps),
//   time step                three multiplies by dt per axis (v*dt, a*dt,
//     (a*dt)*dt), axes x, y, z then angle, each axis then written back,
//   loads, unused codes, force on a static or kinematic body: no serial work.
// Throughput: one item at a time; item.ready is high in idle only, so a
//   new word is taken the cycle after the previous result is registered.
// Stall: the result sits in an output register; the next item is accepted
//   and worked on while it waits, and finishes once the register is free.
// Reset: all state zero, dynamic body, mass and inertia 1.0, no result.
module rigid_body_motion_step import rbms_pkg::*; (
    input logic            clk,
    input logic            rst_n,
    rbms_item_if.sink      item,
    rbms_result_if.source  result,
    rbms_cfg_if.sink       cfg
);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DIV_GO   = 3'd1;
    localparam logic [2:0] S_DIV_WAIT = 3'd2;
    localparam logic [2:0] S_MUL_GO   = 3'd3;
    localparam logic [2:0] S_MUL_WAIT = 3'd4;
    localparam logic [2:0] S_WRITE    = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    // multiply phases of one axis in a time step
    localparam logic [1:0] PH_VT  = 2'd0;   // v*dt
    localparam logic [1:0] PH_AT  = 2'd1;   // a*dt
    localparam logic [1:0] PH_ADT = 2'd2;   // (a*dt)*dt

    // axis slots: x, y, z, then the angular one
    localparam int         AXES     = 4;
    localparam logic [1:0] LIN_LAST = 2'd2;
    localparam logic [1:0] ANG_AXIS = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [1:0] axis_reg,  axis_next;
    logic [1:0] phase_reg, phase_next;
    logic       fault_reg, fault_next;
    logic       res_valid_reg, res_valid_next;
    logic       res_load;

    logic [1:0] type_reg,    type_next;
    word_t      mass_reg,    mass_next;
    word_t      inertia_reg, inertia_next;

    // body state; slot 3 holds the angular quantities
    word_t p_reg [AXES];
    word_t v_reg [AXES];
    word_t a_reg [AXES];
    word_t p_next [AXES];
    word_t v_next [AXES];
    word_t a_next [AXES];

    // item operands; slot 3 holds the torque
    word_t  vec_reg [AXES];
    dt_t    dt_reg;
    word_t  t1_reg;
    mcand_t m2_reg;

    word_t res_pos_reg [3];
    word_t res_vel_reg [3];
    word_t res_ang_reg;
    word_t res_rate_reg;
    logic  res_fault_reg;

    // serial unit hookup
    rbms_cmd_t cmd;
    rbms_sts_t sts;
    word_t     alu_num;
    word_t     alu_den;
    mcand_t    alu_mcand;
    word_t     quot;
    prod_t     prod;

    logic              item_acc;
    word_t             mass_eff;
    logic signed [T2_W-1:0] t2;
    word_t             m2_hi;
    sum_t              pos_sum;
    sum_t              vel_sum;

    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // negative mass acts as 1.0
    assign mass_eff = mass_reg[WORD_W-1] ? FIX_ONE : mass_reg;

    assign alu_num = vec_reg[axis_reg];
    assign alu_den = (axis_reg == ANG_AXIS) ? inertia_reg : mass_eff;

    always_comb
    begin
        case (phase_reg)
            PH_VT:   alu_mcand = mcand_t'(v_reg[axis_reg]);
            PH_AT:   alu_mcand = mcand_t'(a_reg[axis_reg]);
            default: alu_mcand = m2_reg;
        endcase
    end

    rbms_serial_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .num    (alu_num),
        .den    (alu_den),
        .mcand  (alu_mcand),
        .mplier (dt_reg),
        .sts    (sts),
        .quot   (quot),
        .prod   (prod)
    );

    // p + floor(v*dt/2^16) + floor(a*dt*dt/2^33); v + floor(a*dt/2^16)
    assign t2      = prod[PROD_W-1:T2_LSB];
    assign m2_hi   = m2_reg[T1_LSB+WORD_W-1:T1_LSB];
    assign pos_sum = sum_t'(p_reg[axis_reg]) + sum_t'(t1_reg) + sum_t'(t2);
    assign vel_sum = sum_t'(v_reg[axis_reg]) + sum_t'(m2_hi);

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        phase_next     = phase_reg;
        fault_next     = fault_reg;
        res_valid_next = res_valid_reg;
        res_load       = 1'b0;
        type_next      = type_reg;
        mass_next      = mass_reg;
        inertia_next   = inertia_reg;
        p_next         = p_reg;
        v_next         = v_reg;
        a_next         = a_reg;
        cmd            = '0;

        if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_BODY_TYPE: type_next    = cfg.data[1:0];
                REG_BODY_MASS: mass_next    = cfg.data;
                REG_INERTIA:   inertia_next = cfg.data;
                default:       ;
            endcase
        end

        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    fault_next = 1'b0;
                    axis_next  = '0;
                    phase_next = PH_VT;
                    state_next = S_FINISH;
                    case (item.operation)
                        OP_FORCE:
                        begin
                            if (type_reg inside {BODY_STATIC, BODY_KINEMATIC})
                            begin
                                a_next[0] = '0;
                                a_next[1] = '0;
                                a_next[2] = '0;
                            end
                            else
                            begin
                                state_next = S_DIV_GO;
                            end
                        end
                        OP_TORQUE:
                        begin
                            axis_next  = ANG_AXIS;
                            state_next = S_DIV_GO;
                        end
                        OP_STEP:
                        begin
                            state_next = S_MUL_GO;
                        end
                        OP_LOAD_POS:
                        begin
                            p_next[0] = item.vec_x;
                            p_next[1] = item.vec_y;
                            p_next[2] = item.vec_z;
                        end
                        OP_LOAD_VEL:
                        begin
                            v_next[0] = item.vec_x;
                            v_next[1] = item.vec_y;
                            v_next[2] = item.vec_z;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV_GO:
            begin
                cmd.start  = 1'b1;
                cmd.divide = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.done)
                begin
                    a_next[axis_reg] = quot;
                    fault_next       = fault_reg | sts.fault;
                    if (axis_reg == LIN_LAST || axis_reg == ANG_AXIS)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_MUL_GO:
            begin
                cmd.start  = 1'b1;
                cmd.divide = 1'b0;
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (sts.done)
                begin
                    case (phase_reg)
                        PH_VT:
                        begin
                            phase_next = PH_AT;
                            state_next = S_MUL_GO;
                        end
                        PH_AT:
                        begin
                            phase_next = PH_ADT;
                            state_next = S_MUL_GO;
                        end
                        default:
                        begin
                            state_next = S_WRITE;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                p_next[axis_reg] = sat_word(pos_sum);
                // a static body keeps no linear velocity
                if (type_reg == BODY_STATIC && axis_reg != ANG_AXIS)
                begin
                    v_next[axis_reg] = '0;
                end
                else
                begin
                    v_next[axis_reg] = sat_word(vel_sum);
                end
                phase_next = PH_VT;
                if (axis_reg == ANG_AXIS)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_MUL_GO;
                end
            end
            S_FINISH:
            begin
                // wait for the output register to be free
                if (!res_valid_reg || result.ready)
                begin
                    res_load       = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            phase_reg     <= PH_VT;
            fault_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            type_reg      <= BODY_DYNAMIC;
            mass_reg      <= FIX_ONE;
            inertia_reg   <= FIX_ONE;
            for (int i = 0; i < AXES; i++)
            begin
                p_reg[i] <= '0;
                v_reg[i] <= '0;
                a_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            phase_reg     <= phase_next;
            fault_reg     <= fault_next;
            res_valid_reg <= res_valid_next;
            type_reg      <= type_next;
            mass_reg      <= mass_next;
            inertia_reg   <= inertia_next;
            p_reg         <= p_next;
            v_reg         <= v_next;
            a_reg         <= a_next;
        end
    end

    // operand and result words, no reset
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            vec_reg[0]      <= item.vec_x;
            vec_reg[1]      <= item.vec_y;
            vec_reg[2]      <= item.vec_z;
            vec_reg[3]      <= item.torque_value;
            dt_reg          <= item.time_step;
        end
        if (state_reg == S_MUL_WAIT && sts.done)
        begin
            if (phase_reg == PH_VT)
            begin
                t1_reg <= prod[T1_LSB+WORD_W-1:T1_LSB];
            end
            if (phase_reg == PH_AT)
            begin
                m2_reg <= prod[MCAND_W-1:0];
            end
        end
        if (res_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_pos_reg[i] <= p_reg[i];
                res_vel_reg[i] <= v_reg[i];
            end
            res_ang_reg   <= p_reg[ANG_AXIS];
            res_rate_reg  <= v_reg[ANG_AXIS];
            res_fault_reg <= fault_reg;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.pos_x        = res_pos_reg[0];
    assign result.pos_y        = res_pos_reg[1];
    assign result.pos_z        = res_pos_reg[2];
    assign result.vel_x        = res_vel_reg[0];
    assign result.vel_y        = res_vel_reg[1];
    assign result.vel_z        = res_vel_reg[2];
    assign result.body_angle   = res_ang_reg;
    assign result.angular_rate = res_rate_reg;
    assign result.divide_fault = res_fault_reg;

endmodule
